// ===== src/hsi_pkg.sv =====
// ----------------------------------------------------------------------------
// hsi_pkg
// Shared widths, register indexes and beat types for the horizontal shear
// interpolator.
// ----------------------------------------------------------------------------
package hsi_pkg;

  localparam int DIM_W      = 13;  // image_width / image_height registers
  localparam int SLOPE_W    = 16;  // slope register, unsigned fixed point
  localparam int PIX_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // shared multiplier operand widths (signed)
  localparam int MUL_A_W = DIM_W + 1;            // dimension or pixel difference
  localparam int MUL_B_W = SLOPE_W + 1;          // slope or blend fraction
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOPE        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_VALUE   = 3'd4;

  typedef struct packed {
    logic run_last;
    logic row_end;
    logic image_end;
    logic clipped;
  } flags_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    flags_t           flags;
  } beat_t;

endpackage

// ===== src/hsi_mul.sv =====
// ----------------------------------------------------------------------------
// hsi_mul
// Shared signed multiplier with a registered product. Used for the row
// shift, the skew and every blend.
// ----------------------------------------------------------------------------
module hsi_mul (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [hsi_pkg::MUL_A_W-1:0]  a,
  input  logic signed [hsi_pkg::MUL_B_W-1:0]  b,
  output logic signed [hsi_pkg::MUL_P_W-1:0]  prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * b;
    end
  end

endmodule

// ===== src/hsi_obuf.sv =====
// ----------------------------------------------------------------------------
// hsi_obuf
// Single output register on the valid/stall result channel.
// ----------------------------------------------------------------------------
module hsi_obuf (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  hsi_pkg::beat_t din,
  output logic           ok,
  output logic           valid,
  input  logic           stall,
  output hsi_pkg::beat_t dout
);

  assign ok = !valid || !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (!stall) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dout <= din;
    end
  end

endmodule

// ===== src/horizontal_shear_interp.sv =====
// ----------------------------------------------------------------------------
// horizontal_shear_interp
// Streams a raster image through a horizontal shear with linear blending.
//
// Pixels enter one at a time; the sheared image leaves in raster order with
// rows skew+1 pixels wider than the source. One signed multiplier, shared
// under a small sequencer, forms the row shift, the skew and each blend, so
// the block holds one pixel at a time. A middle pixel runs the blend
// multiply and output; a row's first pixel first runs the shift multiply
// and load and k leading fill beats (k = whole part of the row shift);
// a row's last pixel adds the skew multiply and load, the closing blend and
// the trailing fill beats; result-channel stalls hold them. Configuration
// registers may be written between pixels and take effect on the next one.
// ----------------------------------------------------------------------------
module horizontal_shear_interp #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  parameter int MAX_SKEW   = 62,
  parameter int FRAC_BITS  = 12
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration
  input  logic                             cfg_we,
  input  logic [hsi_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [hsi_pkg::CFG_DATA_W-1:0]   cfg_data,
  // source pixels
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [hsi_pkg::PIX_W-1:0]        pixel,
  // sheared pixels
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [hsi_pkg::PIX_W-1:0]        out_pixel,
  output logic                             run_last,
  output logic                             row_end,
  output logic                             image_end,
  output logic                             clipped
);

  localparam int DIM_MAX = (1 << hsi_pkg::DIM_W) - 1;
  localparam int W_EFF   = (MAX_WIDTH < DIM_MAX) ? MAX_WIDTH : DIM_MAX;
  localparam int H_EFF   = (MAX_HEIGHT < DIM_MAX) ? MAX_HEIGHT : DIM_MAX;
  localparam int COL_W   = (W_EFF > 1) ? $clog2(W_EFF) : 1;
  localparam int ROW_W   = (H_EFF > 1) ? $clog2(H_EFF) : 1;
  localparam int SKEW_W  = (MAX_SKEW > 1) ? $clog2(MAX_SKEW + 1) : 1;
  localparam int SH_W    = SKEW_W + FRAC_BITS;
  localparam int DW      = hsi_pkg::DIM_W;
  localparam int PW      = hsi_pkg::PIX_W;
  localparam int PRW     = hsi_pkg::MUL_P_W;

  localparam logic [PRW-1:0]  SHIFT_CAP = PRW'(MAX_SKEW) << FRAC_BITS;
  localparam logic [SH_W-1:0] CAP_SH    = SH_W'(MAX_SKEW) << FRAC_BITS;
  localparam logic [PRW-1:0]  HALF      = PRW'(1) << (FRAC_BITS - 1);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_SHIFT_MUL = 4'd1;
  localparam logic [3:0] S_SHIFT_LD  = 4'd2;
  localparam logic [3:0] S_LEAD      = 4'd3;
  localparam logic [3:0] S_BLEND_MUL = 4'd4;
  localparam logic [3:0] S_BLEND_OUT = 4'd5;
  localparam logic [3:0] S_SKEW_MUL  = 4'd6;
  localparam logic [3:0] S_SKEW_LD   = 4'd7;
  localparam logic [3:0] S_CLOSE_MUL = 4'd8;
  localparam logic [3:0] S_CLOSE_OUT = 4'd9;
  localparam logic [3:0] S_TRAIL     = 4'd10;

  // configuration registers
  logic [DW-1:0]                   image_width;
  logic [DW-1:0]                   image_height;
  logic [hsi_pkg::SLOPE_W-1:0]     slope;
  logic                            direction;
  logic [PW-1:0]                   fill_value;

  // sequencer state
  logic [3:0]        state;
  logic [COL_W-1:0]  column_count;
  logic [ROW_W-1:0]  row_count;
  logic [SH_W-1:0]   shift_accum;
  logic [PW-1:0]     previous_pixel;
  logic              row_clipped;
  logic [SKEW_W-1:0] run_cnt;
  logic [PW-1:0]     cur_pix;
  logic              first;
  logic              last;

  logic [DW-1:0]     w;
  logic [DW-1:0]     h;
  logic              col_end;
  logic              row_last;
  logic [DW-1:0]     re;

  logic                                  mul_en;
  logic signed [hsi_pkg::MUL_A_W-1:0]    mul_a;
  logic signed [hsi_pkg::MUL_B_W-1:0]    mul_b;
  logic signed [PRW-1:0]                 prod;
  logic [PRW-1:0]                        prod_u;

  logic              clip;
  logic [SH_W-1:0]   shift_next;
  logic [SKEW_W-1:0] k_next;
  logic [SKEW_W-1:0] k;
  logic [FRAC_BITS-1:0] f;
  logic [PRW-1:0]    sk;
  logic [SKEW_W-1:0] skew;
  logic [SKEW_W-1:0] trail;

  logic [PW-1:0]     blend_a;
  logic [PW-1:0]     blend_b;
  logic signed [PW:0] diff;
  logic signed [PRW-1:0] rsum;
  logic signed [PRW-1:0] delta;
  logic [PW-1:0]     base;
  logic [PW-1:0]     blend_pix;

  logic              ok;
  logic              load;
  hsi_pkg::beat_t    beat;
  hsi_pkg::beat_t    ob;

  // ---- configuration ----
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DW'(1);
      image_height <= DW'(1);
      slope        <= '0;
      direction    <= 1'b0;
      fill_value   <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        hsi_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[DW-1:0];
        hsi_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data[DW-1:0];
        hsi_pkg::REG_SLOPE:        slope        <= cfg_data[hsi_pkg::SLOPE_W-1:0];
        hsi_pkg::REG_DIRECTION:    direction    <= cfg_data[0];
        hsi_pkg::REG_FILL_VALUE:   fill_value   <= cfg_data[PW-1:0];
        default: ;
      endcase
    end
  end

  // ---- clamped dimensions and row/column bookkeeping ----
  always_comb begin
    if (image_width == '0) begin
      w = DW'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w = DW'(MAX_WIDTH);
    end else begin
      w = image_width;
    end
    if (image_height == '0) begin
      h = DW'(1);
    end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
      h = DW'(MAX_HEIGHT);
    end else begin
      h = image_height;
    end
  end

  assign col_end  = ((DW+1)'(column_count) + (DW+1)'(1)) >= (DW+1)'(w);
  assign row_last = ((DW+1)'(row_count) + (DW+1)'(1)) >= (DW+1)'(h);

  always_comb begin
    if (!direction) begin
      re = DW'(row_count);
    end else if (DW'(row_count) >= h) begin
      re = '0;
    end else begin
      re = h - DW'(1) - DW'(row_count);
    end
  end

  // ---- shared multiplier ----
  assign blend_a = (state == S_CLOSE_MUL) ? cur_pix : (first ? fill_value : previous_pixel);
  assign blend_b = (state == S_CLOSE_MUL) ? fill_value : cur_pix;
  assign diff    = $signed({1'b0, blend_a}) - $signed({1'b0, blend_b});

  always_comb begin
    mul_en = 1'b0;
    mul_a  = $signed({1'b0, re});
    mul_b  = $signed({1'b0, slope});
    case (state)
      S_SHIFT_MUL: begin
        mul_en = 1'b1;
      end
      S_SKEW_MUL: begin
        mul_en = 1'b1;
        mul_a  = $signed({1'b0, h});
      end
      S_BLEND_MUL, S_CLOSE_MUL: begin
        mul_en = 1'b1;
        mul_a  = $signed({{(hsi_pkg::MUL_A_W-PW-1){diff[PW]}}, diff});
        mul_b  = $signed({{(hsi_pkg::MUL_B_W-FRAC_BITS){1'b0}}, f});
      end
      default: ;
    endcase
  end

  hsi_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign prod_u = prod;

  // row shift, capped
  assign clip       = prod_u > SHIFT_CAP;
  assign shift_next = clip ? CAP_SH : prod_u[SH_W-1:0];
  assign k_next     = shift_next[SH_W-1 -: SKEW_W];
  assign k          = shift_accum[SH_W-1 -: SKEW_W];
  assign f          = shift_accum[FRAC_BITS-1:0];

  // skew and trailing fill count
  assign sk    = prod_u >> FRAC_BITS;
  assign skew  = (sk > PRW'(MAX_SKEW)) ? SKEW_W'(MAX_SKEW) : sk[SKEW_W-1:0];
  assign trail = (skew > k) ? (skew - k) : '0;

  // blend = b + round(f*(a-b) / ONE), halves up
  assign rsum      = prod + $signed(HALF);
  assign delta     = rsum >>> FRAC_BITS;
  assign base      = (state == S_CLOSE_OUT) ? fill_value : cur_pix;
  assign blend_pix = base + delta[PW-1:0];

  // ---- result beats ----
  always_comb begin
    load                 = 1'b0;
    beat.pix             = fill_value;
    beat.flags.run_last  = 1'b0;
    beat.flags.row_end   = 1'b0;
    beat.flags.image_end = 1'b0;
    beat.flags.clipped   = row_clipped;
    case (state)
      S_LEAD: begin
        load = ok;
      end
      S_BLEND_OUT: begin
        load                = ok;
        beat.pix            = blend_pix;
        beat.flags.run_last = !last;
      end
      S_CLOSE_OUT: begin
        load     = ok;
        beat.pix = blend_pix;
        if (run_cnt == '0) begin
          beat.flags.run_last  = 1'b1;
          beat.flags.row_end   = 1'b1;
          beat.flags.image_end = row_last;
        end
      end
      S_TRAIL: begin
        load = ok;
        if (run_cnt == SKEW_W'(1)) begin
          beat.flags.run_last  = 1'b1;
          beat.flags.row_end   = 1'b1;
          beat.flags.image_end = row_last;
        end
      end
      default: ;
    endcase
  end

  hsi_obuf u_obuf (
    .clk   (clk),
    .rst   (rst),
    .load  (load),
    .din   (beat),
    .ok    (ok),
    .valid (out_valid),
    .stall (out_stall),
    .dout  (ob)
  );

  assign out_pixel = ob.pix;
  assign run_last  = ob.flags.run_last;
  assign row_end   = ob.flags.row_end;
  assign image_end = ob.flags.image_end;
  assign clipped   = ob.flags.clipped;

  assign in_stall = (state != S_IDLE);

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      column_count   <= '0;
      row_count      <= '0;
      shift_accum    <= '0;
      previous_pixel <= '0;
      row_clipped    <= 1'b0;
      run_cnt        <= '0;
      cur_pix        <= '0;
      first          <= 1'b0;
      last           <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur_pix <= pixel;
            first   <= (column_count == '0);
            last    <= col_end;
            state   <= (column_count == '0) ? S_SHIFT_MUL : S_BLEND_MUL;
          end
        end
        S_SHIFT_MUL: begin
          state <= S_SHIFT_LD;
        end
        S_SHIFT_LD: begin
          shift_accum <= shift_next;
          row_clipped <= clip;
          run_cnt     <= k_next;
          state       <= (k_next != '0) ? S_LEAD : S_BLEND_MUL;
        end
        S_LEAD: begin
          if (ok) begin
            run_cnt <= run_cnt - SKEW_W'(1);
            if (run_cnt == SKEW_W'(1)) begin
              state <= S_BLEND_MUL;
            end
          end
        end
        S_BLEND_MUL: begin
          state <= S_BLEND_OUT;
        end
        S_BLEND_OUT: begin
          if (ok) begin
            if (last) begin
              state <= S_SKEW_MUL;
            end else begin
              column_count   <= column_count + COL_W'(1);
              previous_pixel <= cur_pix;
              state          <= S_IDLE;
            end
          end
        end
        S_SKEW_MUL: begin
          state <= S_SKEW_LD;
        end
        S_SKEW_LD: begin
          run_cnt <= trail;
          state   <= S_CLOSE_MUL;
        end
        S_CLOSE_MUL: begin
          state <= S_CLOSE_OUT;
        end
        S_CLOSE_OUT, S_TRAIL: begin
          if (ok) begin
            if (state == S_TRAIL) begin
              run_cnt <= run_cnt - SKEW_W'(1);
            end
            if ((state == S_CLOSE_OUT && run_cnt == '0) ||
                (state == S_TRAIL && run_cnt == SKEW_W'(1))) begin
              // row done
              column_count   <= '0;
              row_count      <= row_last ? '0 : row_count + ROW_W'(1);
              previous_pixel <= cur_pix;
              state          <= S_IDLE;
            end else begin
              state <= S_TRAIL;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ---- checks ----
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("pixel accepted while previous one still in work");

  a_clip_at_cap: assert property (@(posedge clk) disable iff (rst)
    row_clipped |-> shift_accum == CAP_SH)
    else $error("clipped row with shift other than the cap");

  a_image_end_closes: assert property (@(posedge clk) disable iff (rst)
    load && beat.flags.image_end |-> beat.flags.row_end && beat.flags.run_last)
    else $error("image end beat does not close the row and the run");

  a_trail_count: assert property (@(posedge clk) disable iff (rst)
    state == S_TRAIL |-> run_cnt != '0)
    else $error("trailing fill with empty count");

endmodule
